FILE: rtl/core/teq_pkg.sv
// teq_pkg: shared types and codes for the timed event queue
// no dependencies
`default_nettype none
package teq_pkg;
	typedef enum logic [2:0] {
		CMD_POST = 3'd0,
		CMD_TAKE = 3'd1,
		CMD_QUERY = 3'd2,
		CMD_REMOVE = 3'd3,
		CMD_CLEAR = 3'd4,
		CMD_QUIT = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_DONE = 3'd0,
		ST_NO_TARGET = 3'd1,
		ST_FULL = 3'd2,
		ST_NOT_DUE = 3'd3,
		ST_QUITTING = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INSERT = 2'd1,
		OP_SHIFT = 2'd2,
		OP_COMPACT = 2'd3
	} cell_op_t;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		cell_op_t op;
		logic     zero_time;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_COMPACT = 2'd1,
		S_OUT = 2'd2
	} seq_state_t;
endpackage
`default_nettype wire

FILE: rtl/core/teq_cell.sv
// teq_cell: one slot of the sorted event chain
// depends on teq_pkg
`default_nettype none
module teq_cell import teq_pkg::*; #(
	parameter int TIME_BITS = 48
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cell_ctl_t            ctl,
	input  wire logic [TIME_BITS-1:0] new_when,
	input  wire logic [31:0]          new_what,
	input  wire logic [7:0]           new_handler,
	input  wire logic [7:0]           new_tag,
	input  wire logic [31:0]          match_what,
	input  wire logic [7:0]           match_handler,
	// left neighbor (toward head)
	input  wire logic                 prev_valid,
	input  wire logic                 prev_goes_after,
	input  wire logic                 prev_shift,
	input  wire logic [TIME_BITS-1:0] prev_when,
	input  wire logic [31:0]          prev_what,
	input  wire logic [7:0]           prev_handler,
	input  wire logic [7:0]           prev_tag,
	// right neighbor (toward tail)
	input  wire logic                 next_valid,
	input  wire logic [TIME_BITS-1:0] next_when,
	input  wire logic [31:0]          next_what,
	input  wire logic [7:0]           next_handler,
	input  wire logic [7:0]           next_tag,
	input  wire logic                 clear,
	output logic                      valid,
	output logic                      goes_after,
	output logic                      shift,
	output logic                      drop,
	output logic [TIME_BITS-1:0]      when_q,
	output logic [31:0]               what_q,
	output logic [7:0]                handler_q,
	output logic [7:0]                tag_q
);
	logic valid_q;

	assign valid = valid_q;
	// new event lands behind this entry
	assign goes_after = valid_q && !ctl.zero_time && !(new_when < when_q);
	assign drop = valid_q && what_q == match_what && handler_q == match_handler;
	// compaction pass: this cell and all behind the first match move up one
	assign shift = drop || prev_shift;

	// control bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				OP_INSERT: valid_q <= valid_q || prev_valid;
				OP_SHIFT: valid_q <= next_valid;
				OP_COMPACT: if (shift) valid_q <= next_valid;
				default: valid_q <= valid_q;
			endcase
		end
	end

	// payload moves
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_INSERT: begin
				if (!goes_after) begin
					if (prev_goes_after) begin
						when_q <= new_when;
						what_q <= new_what;
						handler_q <= new_handler;
						tag_q <= new_tag;
					end else if (prev_valid) begin
						when_q <= prev_when;
						what_q <= prev_what;
						handler_q <= prev_handler;
						tag_q <= prev_tag;
					end
				end
			end
			OP_SHIFT: begin
				when_q <= next_when;
				what_q <= next_what;
				handler_q <= next_handler;
				tag_q <= next_tag;
			end
			OP_COMPACT: begin
				if (shift) begin
					when_q <= next_when;
					what_q <= next_what;
					handler_q <= next_handler;
					tag_q <= next_tag;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/core/timed_event_queue.sv
// timed_event_queue: top level, cell chain plus command sequencer
// depends on teq_pkg and teq_cell
// Sorted queue of timed events held in a chain of cells, head in cell 0.
// Each command is captured at the input transfer, worked in the compaction
// state, where the chain is updated and the result register filled, and
// shown in the output state until the result transfers out. Remove-matching
// stays in the compaction state while matching events remain, since each
// compaction pass moves the chain behind the first match up by one cell.
// One command is worked at a time.
`default_nettype none
module timed_event_queue import teq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TIME_BITS = 48
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [2:0]           cmd,
	input  wire logic [7:0]           msg_tag,
	input  wire logic signed [31:0]   what_code,
	input  wire logic [7:0]           handler_id,
	input  wire logic [TIME_BITS-1:0] when_ms,
	input  wire logic [TIME_BITS-1:0] now_ms,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [2:0]                status,
	output logic                      found,
	output logic [7:0]                out_tag,
	output logic signed [31:0]        out_what,
	output logic [7:0]                out_handler,
	output logic [47:0]               out_when
);
	localparam int N = QUEUE_DEPTH;

	seq_state_t state_q, state_d;
	cell_ctl_t ctl;
	logic clear;

	// chain taps: entry 0 virtual head, entries 1..N the cells, entry N+1 empty tail
	logic [N+1:0] v;
	logic [N:0] ga, sh;
	logic [TIME_BITS-1:0] cw [N+2];
	logic [31:0] cwh [N+2];
	logic [7:0] ch [N+2];
	logic [7:0] ct [N+2];
	logic [N-1:0] cdr;

	logic [2:0] cmd_q;
	logic [7:0] tag_q, hnd_q;
	logic [31:0] what_q;
	logic [TIME_BITS-1:0] when_q, now_q;
	logic quit_q;
	logic [2:0] status_q;
	logic found_q;
	logic [7:0] otag_q, ohnd_q;
	logic [31:0] owhat_q;
	logic [47:0] owhen_q;
	logic full, take_ok;

	// chain ends: virtual head that every event goes after, empty tail
	assign v[0] = 1'b1;
	assign ga[0] = 1'b1;
	assign sh[0] = 1'b0;
	assign cw[0] = '0;
	assign cwh[0] = '0;
	assign ch[0] = '0;
	assign ct[0] = '0;
	assign v[N+1] = 1'b0;
	assign cw[N+1] = '0;
	assign cwh[N+1] = '0;
	assign ch[N+1] = '0;
	assign ct[N+1] = '0;

	for (genvar g = 0; g < N; g++) begin : g_cell
		teq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.new_when(when_q), .new_what(what_q), .new_handler(hnd_q),
			.new_tag(tag_q), .match_what(what_q), .match_handler(hnd_q),
			.prev_valid(v[g]), .prev_goes_after(ga[g]), .prev_shift(sh[g]),
			.prev_when(cw[g]), .prev_what(cwh[g]),
			.prev_handler(ch[g]), .prev_tag(ct[g]),
			.next_valid(v[g+2]),
			.next_when(cw[g+2]), .next_what(cwh[g+2]),
			.next_handler(ch[g+2]), .next_tag(ct[g+2]),
			.clear(clear),
			.valid(v[g+1]), .goes_after(ga[g+1]), .shift(sh[g+1]), .drop(cdr[g]),
			.when_q(cw[g+1]), .what_q(cwh[g+1]), .handler_q(ch[g+1]), .tag_q(ct[g+1])
		);
	end

	assign full = v[N];
	assign take_ok = !quit_q && v[1] && !(now_q < cw[1]);

	// command capture
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_q <= cmd;
			tag_q <= msg_tag;
			what_q <= what_code;
			hnd_q <= handler_id;
			when_q <= when_ms;
			now_q <= now_ms;
		end
	end

	// sequencer next state and chain control
	always_comb begin
		state_d = state_q;
		ctl = '{op: OP_HOLD, zero_time: (when_q == '0)};
		clear = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_COMPACT;
			S_COMPACT: begin
				unique case (cmd_q)
					CMD_POST: begin
						if (hnd_q != '0 && !full) ctl.op = OP_INSERT;
						state_d = S_OUT;
					end
					CMD_TAKE: begin
						if (take_ok) ctl.op = OP_SHIFT;
						state_d = S_OUT;
					end
					CMD_REMOVE: begin
						if (|cdr) ctl.op = OP_COMPACT;
						else state_d = S_OUT;
					end
					CMD_CLEAR: begin
						clear = 1'b1;
						state_d = S_OUT;
					end
					default: state_d = S_OUT;
				endcase
			end
			S_OUT: if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			quit_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_COMPACT && cmd_q == CMD_QUIT) quit_q <= 1'b1;
		end
	end

	// result register, filled in the compaction state (for remove, on its last pass)
	always_ff @(posedge clk) begin
		if (state_q == S_COMPACT) begin
			if (!(cmd_q == CMD_REMOVE && |cdr)) begin
				status_q <= ST_DONE;
				found_q <= 1'b0;
				otag_q <= '0;
				owhat_q <= '0;
				ohnd_q <= '0;
				owhen_q <= '0;
			end
			unique case (cmd_q)
				CMD_POST: begin
					if (hnd_q == '0) status_q <= ST_NO_TARGET;
					else if (full) status_q <= ST_FULL;
				end
				CMD_TAKE: begin
					if (quit_q) status_q <= ST_QUITTING;
					else if (!take_ok) status_q <= ST_NOT_DUE;
					else begin
						otag_q <= ct[1];
						owhat_q <= cwh[1];
						ohnd_q <= ch[1];
						owhen_q <= 48'(cw[1]);
					end
				end
				CMD_QUERY: found_q <= |cdr;
				default: begin
				end
			endcase
		end
	end

	assign in_stall = state_q != S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign status = status_q;
	assign found = found_q;
	assign out_tag = otag_q;
	assign out_what = owhat_q;
	assign out_handler = ohnd_q;
	assign out_when = owhen_q;
endmodule
`default_nettype wire

FILE: rtl/core/teq_checker.sv
// teq_sva: port-level checks for timed_event_queue
// depends on teq_pkg; bound to the top level
`default_nettype none
module teq_sva import teq_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [2:0] status,
	input wire logic       found
);
	// one item in flight: no input transfer while a result waits
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken with result pending");
	// found only with done status
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == ST_DONE) else $error("found with bad status");
	// status codes in range
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_QUITTING) else $error("bad status");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)) else $error("result dropped");
endmodule

bind timed_event_queue teq_sva u_teq_sva (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status), .found(found)
);
`default_nettype wire
